// ===== hdl/udrc_pkg.sv =====
// Shared types and constants of the UDP receive checker.
package udrc_pkg;

  localparam int unsigned CNT_W     = 17;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned ADDR_SUM_W = 19;
  localparam int unsigned VERDICT_W = 3;
  localparam int unsigned PLEN_W    = 12;

  localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1ffff;
  localparam logic [CNT_W-1:0] HDR_BYTES = 17'd8;
  localparam logic [CNT_W-1:0] SEG_MAX   = 17'd65535;
  localparam logic [CNT_W-1:0] PLEN_FIELD_MAX = 17'd4095;
  localparam logic [ADDR_SUM_W-1:0] PROTO_UDP = 19'd17;

  localparam logic [VERDICT_W-1:0] VERDICT_OK        = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_LEN   = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_LARGE = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_CSUM  = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_ZERO_PORT = 3'd4;

  // Everything the verdict stage needs about one finished segment.
  typedef struct packed {
    logic [CNT_W-1:0]      byte_count;
    logic [SUM_W-1:0]      run_sum;
    logic [7:0]            hold;
    logic [15:0]           src_port;
    logic [15:0]           dst_port;
    logic [15:0]           hdr_len;
    logic [15:0]           hdr_csum;
    logic [ADDR_SUM_W-1:0] addr_sum;
  } seg_sum_t;

endpackage

// ===== hdl/udrc_if.sv =====
// Channel interfaces of the UDP receive checker: input words, results, configuration.
interface udrc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;

  modport source (output valid, data_byte, last_byte, src_ip, dst_ip, input ready);
  modport sink (input valid, data_byte, last_byte, src_ip, dst_ip, output ready);
endinterface

interface udrc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [11:0] pay_len;

  modport source (output valid, verdict, src_port, dst_port, pay_len, input ready);
  modport sink (input valid, verdict, src_port, dst_port, pay_len, output ready);
endinterface

interface udrc_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/udp_datagram_rx_checker.sv =====
// Top level of the UDP receive checker with its configuration register.
//
// The block takes a UDP segment one byte per word on the in_ channel, header
// first, with the IPv4 source and destination addresses beside each byte;
// the addresses are used only on the word flagged last_byte. For every
// segment it returns one result word on the out_ channel: a verdict (ok,
// bad length, too large, bad checksum, zero destination port, checked in
// that order), the two ports and the payload length. Words that are not
// last produce no result.
// A word is taken in every cycle in which in_ready is high; the per-byte
// ones-complement add and header capture sit between the input register and
// the segment register, and the checksum fold and checks between that
// register and the result register.
// The cfg_ channel writes the zero-checksum enable bit; it is always ready
// and must only be written while no segment is in flight.
// Synchronous reset clears the segment state, the configuration bit and all
// valid flags. When the receiver stalls, the result register holds its word
// and bytes keep flowing; in_ready drops only when a last byte waits in the
// input register while both the segment and the result register are full.
module udp_datagram_rx_checker import udrc_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 2048
) (
  input  logic      clk,
  input  logic      rst_n,
  udrc_in_if.sink   in_ch,
  udrc_out_if.source out_ch,
  udrc_cfg_if.sink  cfg_ch
);

  logic     allow_zero_csum_r;
  logic     seg_valid;
  logic     seg_take;
  seg_sum_t seg_sum;

  // The configuration register is always free to take a write.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_zero_csum_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      allow_zero_csum_r <= cfg_ch.data;
    end
  end

  udrc_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_data_byte (in_ch.data_byte),
    .in_last_byte (in_ch.last_byte),
    .in_src_ip    (in_ch.src_ip),
    .in_dst_ip    (in_ch.dst_ip),
    .seg_valid    (seg_valid),
    .seg_sum      (seg_sum),
    .seg_take     (seg_take)
  );

  udrc_verdict #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_verdict (
    .clk             (clk),
    .rst_n           (rst_n),
    .allow_zero_csum (allow_zero_csum_r),
    .seg_valid       (seg_valid),
    .seg_sum         (seg_sum),
    .seg_take        (seg_take),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_verdict     (out_ch.verdict),
    .out_src_port    (out_ch.src_port),
    .out_dst_port    (out_ch.dst_port),
    .out_pay_len     (out_ch.pay_len)
  );

endmodule

// ===== hdl/udrc_accum.sv =====
// Input register, per-word checksum accumulation and header capture.
module udrc_accum import udrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  output logic        seg_valid,
  output seg_sum_t    seg_sum,
  input  logic        seg_take
);

  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic             in_last_r;
  logic [31:0]      in_src_r;
  logic [31:0]      in_dst_r;

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [SUM_W-1:0] run_sum_r, run_sum_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic [15:0]      src_port_r, src_port_nxt;
  logic [15:0]      dst_port_r, dst_port_nxt;
  logic [15:0]      hdr_len_r, hdr_len_nxt;
  logic [15:0]      hdr_csum_r, hdr_csum_nxt;
  logic             seg_valid_r;
  seg_sum_t         seg_sum_r;

  logic             seg_free;
  logic             proc;
  logic [SUM_W:0]   add17;
  logic [ADDR_SUM_W-1:0] addr_sum;

  assign seg_free = !seg_valid_r || seg_take;
  assign proc     = in_valid_r && (!in_last_r || seg_free);
  assign in_ready = !in_valid_r || proc;

  // One ones-complement word add; a single end-around carry is enough here.
  assign add17 = {1'b0, run_sum_r} + {1'b0, hold_r, in_byte_r};

  assign addr_sum = ADDR_SUM_W'(in_src_r[31:16]) + ADDR_SUM_W'(in_src_r[15:0])
                  + ADDR_SUM_W'(in_dst_r[31:16]) + ADDR_SUM_W'(in_dst_r[15:0])
                  + PROTO_UDP;

  always_comb begin
    byte_count_nxt = byte_count_r;
    run_sum_nxt    = run_sum_r;
    hold_nxt       = hold_r;
    src_port_nxt   = src_port_r;
    dst_port_nxt   = dst_port_r;
    hdr_len_nxt    = hdr_len_r;
    hdr_csum_nxt   = hdr_csum_r;
    if (byte_count_r != COUNT_MAX) begin
      byte_count_nxt = byte_count_r + 1'b1;
      if (!byte_count_r[0]) begin
        hold_nxt = in_byte_r;
      end else begin
        run_sum_nxt = add17[SUM_W-1:0] + SUM_W'(add17[SUM_W]);
      end
      if (byte_count_r[CNT_W-1:3] == '0) begin
        case (byte_count_r[2:0])
          3'd0: src_port_nxt[15:8] = in_byte_r;
          3'd1: src_port_nxt[7:0]  = in_byte_r;
          3'd2: dst_port_nxt[15:8] = in_byte_r;
          3'd3: dst_port_nxt[7:0]  = in_byte_r;
          3'd4: hdr_len_nxt[15:8]  = in_byte_r;
          3'd5: hdr_len_nxt[7:0]   = in_byte_r;
          3'd6: hdr_csum_nxt[15:8] = in_byte_r;
          default: hdr_csum_nxt[7:0] = in_byte_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
      in_src_r  <= in_src_ip;
      in_dst_r  <= in_dst_ip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      run_sum_r    <= '0;
      hold_r       <= '0;
      src_port_r   <= '0;
      dst_port_r   <= '0;
      hdr_len_r    <= '0;
      hdr_csum_r   <= '0;
      seg_valid_r  <= 1'b0;
    end else begin
      if (proc && in_last_r) begin
        byte_count_r <= '0;
        run_sum_r    <= '0;
        hold_r       <= '0;
        src_port_r   <= '0;
        dst_port_r   <= '0;
        hdr_len_r    <= '0;
        hdr_csum_r   <= '0;
        seg_valid_r  <= 1'b1;
      end else begin
        if (proc) begin
          byte_count_r <= byte_count_nxt;
          run_sum_r    <= run_sum_nxt;
          hold_r       <= hold_nxt;
          src_port_r   <= src_port_nxt;
          dst_port_r   <= dst_port_nxt;
          hdr_len_r    <= hdr_len_nxt;
          hdr_csum_r   <= hdr_csum_nxt;
        end
        if (seg_take) begin
          seg_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_last_r) begin
      seg_sum_r.byte_count <= byte_count_nxt;
      seg_sum_r.run_sum    <= run_sum_nxt;
      seg_sum_r.hold       <= hold_nxt;
      seg_sum_r.src_port   <= src_port_nxt;
      seg_sum_r.dst_port   <= dst_port_nxt;
      seg_sum_r.hdr_len    <= hdr_len_nxt;
      seg_sum_r.hdr_csum   <= hdr_csum_nxt;
      seg_sum_r.addr_sum   <= addr_sum;
    end
  end

  assign seg_valid = seg_valid_r;
  assign seg_sum   = seg_sum_r;

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_last_r |=> byte_count_r == '0)
    else $error("byte count not cleared after last word");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !in_last_r && byte_count_r != COUNT_MAX
      |=> byte_count_r == $past(byte_count_r) + 1'b1)
    else $error("byte count did not advance by one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    seg_valid_r && !seg_take |=> seg_valid_r && $stable(seg_sum_r))
    else $error("pending segment summary was overwritten");
`endif

endmodule

// ===== hdl/udrc_verdict.sv =====
// Checksum fold, length checks and the result register.
module udrc_verdict import udrc_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        allow_zero_csum,
  input  logic        seg_valid,
  input  seg_sum_t    seg_sum,
  output logic        seg_take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  output logic [11:0] out_pay_len
);

  localparam logic [CNT_W-1:0] MAX_PLEN = CNT_W'(MAX_PAYLOAD);

  logic                 out_valid_r;
  logic [VERDICT_W-1:0] verdict_r, verdict_nxt;
  logic [15:0]          src_port_r;
  logic [15:0]          dst_port_r;
  logic [PLEN_W-1:0]    plen_r, plen_nxt;

  logic                 out_adv;
  logic [19:0]          total;
  logic [16:0]          fold1;
  logic [15:0]          fold2;
  logic [15:0]          pad;
  logic [CNT_W-1:0]     plen_full;
  logic                 bad_len;

  assign out_adv  = !out_valid_r || out_ready;
  assign seg_take = seg_valid && out_adv;

  // The whole sum is congruent modulo 0xffff and never zero, so a wide add
  // followed by two end-around folds gives the same word as word-by-word adds.
  assign pad   = seg_sum.byte_count[0] ? {seg_sum.hold, 8'h00} : 16'h0000;
  assign total = 20'(seg_sum.run_sum) + 20'(pad) + 20'(seg_sum.addr_sum)
               + 20'(seg_sum.byte_count);
  assign fold1 = 17'(total[15:0]) + 17'(total[19:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  assign plen_full = seg_sum.byte_count - HDR_BYTES;
  assign bad_len   = seg_sum.byte_count < HDR_BYTES || seg_sum.byte_count > SEG_MAX
                  || {1'b0, seg_sum.hdr_len} != seg_sum.byte_count;

  always_comb begin
    verdict_nxt = VERDICT_OK;
    plen_nxt    = '0;
    if (bad_len) begin
      verdict_nxt = VERDICT_BAD_LEN;
    end else begin
      if (plen_full > MAX_PLEN) begin
        verdict_nxt = VERDICT_TOO_LARGE;
      end else if (seg_sum.hdr_csum == 16'h0000) begin
        verdict_nxt = allow_zero_csum ? VERDICT_OK : VERDICT_BAD_CSUM;
      end else if (fold2 != 16'hffff) begin
        verdict_nxt = VERDICT_BAD_CSUM;
      end
      if (verdict_nxt == VERDICT_OK && seg_sum.dst_port == 16'h0000) begin
        verdict_nxt = VERDICT_ZERO_PORT;
      end
      plen_nxt = (plen_full > PLEN_FIELD_MAX) ? '1 : plen_full[PLEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_take) begin
      verdict_r  <= verdict_nxt;
      src_port_r <= seg_sum.src_port;
      dst_port_r <= seg_sum.dst_port;
      plen_r     <= plen_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_verdict  = verdict_r;
  assign out_src_port = src_port_r;
  assign out_dst_port = dst_port_r;
  assign out_pay_len  = plen_r;

`ifndef SYNTHESIS
  a_bad_len_zero_plen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r == VERDICT_BAD_LEN |-> plen_r == '0)
    else $error("payload length reported on a bad-length segment");

  a_ok_port_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r == VERDICT_OK |-> dst_port_r != 16'h0000)
    else $error("ok verdict with zero destination port");

  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    seg_take |=> out_valid_r)
    else $error("taken segment did not reach the result register");
`endif

endmodule

// ===== bench/udrc_result_checker.sv =====
`timescale 1ns / 1ps
// Verdict checker of the UDP receive checker: predicts every result word and compares it.
module udrc_result_checker import udrc_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  udrc_in_if          in_mon,
  udrc_out_if         out_mon,
  udrc_cfg_if         cfg_mon,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned verdicts_checked
);

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [15:0]          src_port;
    logic [15:0]          dst_port;
    logic [PLEN_W-1:0]    payload_len;
  } udp_verdict_t;

  udp_verdict_t expected_verdicts[$];

  logic             zero_csum_ok;
  logic [CNT_W-1:0] byte_tally;
  logic [SUM_W-1:0] word_sum;
  logic [7:0]       pending_high;
  logic [15:0]      cap_sport;
  logic [15:0]      cap_dport;
  logic [15:0]      cap_len;
  logic [15:0]      cap_csum;

  // End-around-carry add, folded back to 16 bits.
  function automatic logic [SUM_W-1:0] ones_add(input logic [SUM_W-1:0] acc,
                                               input logic [31:0] addend);
    logic [31:0] s;
    s = 32'(acc) + addend;
    while (s[31:16] != 16'h0) s = 32'(s[15:0]) + 32'(s[31:16]);
    return s[SUM_W-1:0];
  endfunction

  task automatic restart_segment();
    byte_tally   = '0;
    word_sum     = '0;
    pending_high = '0;
    cap_sport    = '0;
    cap_dport    = '0;
    cap_len      = '0;
    cap_csum     = '0;
  endtask

  task automatic report(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // Folds one accepted byte into the segment state; on the last byte it works
  // out the verdict word the block has to return.
  task automatic predict_on_byte(input logic [7:0] b, input logic last,
                                 input logic [31:0] src, input logic [31:0] dst);
    logic [SUM_W-1:0] total;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] plen;
    udp_verdict_t     want;
    if (byte_tally < COUNT_MAX) begin
      if (!byte_tally[0]) pending_high = b;
      else word_sum = ones_add(word_sum, {16'h0, pending_high, b});
      case (byte_tally)
        17'd0: cap_sport = {b, 8'h00};
        17'd1: cap_sport[7:0] = b;
        17'd2: cap_dport = {b, 8'h00};
        17'd3: cap_dport[7:0] = b;
        17'd4: cap_len = {b, 8'h00};
        17'd5: cap_len[7:0] = b;
        17'd6: cap_csum = {b, 8'h00};
        17'd7: cap_csum[7:0] = b;
        default: ;
      endcase
      byte_tally = byte_tally + 1'b1;
    end
    if (last) begin
      n = byte_tally;
      total = word_sum;
      if (n[0]) total = ones_add(total, {16'h0, pending_high, 8'h00});
      total = ones_add(total, {16'h0, src[31:16]});
      total = ones_add(total, {16'h0, src[15:0]});
      total = ones_add(total, {16'h0, dst[31:16]});
      total = ones_add(total, {16'h0, dst[15:0]});
      total = ones_add(total, 32'(PROTO_UDP));
      total = ones_add(total, 32'(n));
      want.src_port    = cap_sport;
      want.dst_port    = cap_dport;
      want.payload_len = '0;
      if (n < HDR_BYTES || n > SEG_MAX || 17'(cap_len) != n) begin
        want.verdict = VERDICT_BAD_LEN;
      end else begin
        plen = n - HDR_BYTES;
        if (plen > MAX_PAYLOAD) want.verdict = VERDICT_TOO_LARGE;
        else if (cap_csum == 16'h0) want.verdict = zero_csum_ok ? VERDICT_OK : VERDICT_BAD_CSUM;
        else want.verdict = (~total != 16'h0) ? VERDICT_BAD_CSUM : VERDICT_OK;
        if (want.verdict == VERDICT_OK && cap_dport == 16'h0) want.verdict = VERDICT_ZERO_PORT;
        want.payload_len = (plen > PLEN_FIELD_MAX) ? PLEN_FIELD_MAX[PLEN_W-1:0]
                                                   : plen[PLEN_W-1:0];
      end
      expected_verdicts.push_back(want);
      restart_segment();
    end
  endtask

  always @(posedge clk) begin : watch
    udp_verdict_t oldest;
    if (!rst_n) begin
      zero_csum_ok = 1'b0;
      restart_segment();
      expected_verdicts.delete();
      mismatches = 0;
      verdicts_checked = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) zero_csum_ok = cfg_mon.data;
      if (in_mon.valid && in_mon.ready)
        predict_on_byte(in_mon.data_byte, in_mon.last_byte, in_mon.src_ip, in_mon.dst_ip);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_verdicts.size() == 0) begin
          report($sformatf("result with no segment pending: verdict %0d ports %0d/%0d len %0d",
                           out_mon.verdict, out_mon.src_port, out_mon.dst_port,
                           out_mon.pay_len));
        end else begin
          oldest = expected_verdicts.pop_front();
          verdicts_checked++;
          if (out_mon.verdict !== oldest.verdict)
            report($sformatf("verdict got %0d expected %0d", out_mon.verdict, oldest.verdict));
          if (out_mon.src_port !== oldest.src_port)
            report($sformatf("src_port got %h expected %h", out_mon.src_port,
                             oldest.src_port));
          if (out_mon.dst_port !== oldest.dst_port)
            report($sformatf("dst_port got %h expected %h", out_mon.dst_port,
                             oldest.dst_port));
          if (out_mon.pay_len !== oldest.payload_len)
            report($sformatf("pay_len got %0d expected %0d", out_mon.pay_len,
                             oldest.payload_len));
        end
      end
    end
    outstanding = expected_verdicts.size();
  end

endmodule

// ===== bench/tb_udp_datagram_rx_checker.sv =====
`timescale 1ns / 1ps
// Testbench top of the UDP receive checker: clock, reset, segment stimulus and verdict.
module tb_udp_datagram_rx_checker;

  localparam int unsigned MAX_PAYLOAD    = 2048;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned RANDOM_BYTES   = 440;
  localparam int unsigned RANDOM_SEGS    = 24;
  localparam int unsigned PHASE_SEGS     = 8;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned IDLE_PERCENT   = 13;

  // How the checksum field of a generated segment is filled.
  typedef enum int {CSUM_GOOD, CSUM_WRONG, CSUM_ZERO} csum_kind_t;

  logic clk = 1'b0;
  logic rst_n;
  // While set, neither the sender nor the receiver idles.
  logic steady;

  udrc_in_if  in_ch();
  udrc_out_if out_ch();
  udrc_cfg_if cfg_ch();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned verdicts_checked;
  int unsigned quiet_cycles;
  int unsigned bytes_sent;
  int unsigned segments_sent;
  int unsigned cfg_writes;
  int unsigned random_start;
  int unsigned random_segs;
  int unsigned pick;
  int unsigned seg_len;
  logic [15:0] sport;
  logic [15:0] dport;
  logic [31:0] src;
  logic [31:0] dst;

  // Bytes of the segment currently being sent, header first.
  logic [7:0] seg[$];

  udp_datagram_rx_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  udrc_result_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) verdict_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .cfg_mon          (cfg_ch),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .verdicts_checked (verdicts_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls in about one cycle out of eight, except in steady stretches.
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99, 0) >= IDLE_PERCENT);
  end

  // Watchdog: a run of cycles in which no word moves on any channel means the
  // block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("udp_datagram_rx_checker verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Ones-complement add used to build valid checksums for the stimulus.
  function automatic logic [15:0] csum_add(input logic [15:0] acc, input logic [31:0] v);
    logic [31:0] s;
    s = 32'(acc) + v;
    while (s[31:16] != 16'h0) s = 32'(s[15:0]) + 32'(s[31:16]);
    return s[15:0];
  endfunction

  // Builds one segment of seg_total bytes and sends it word by word. The
  // header carries the given ports; the length field either matches the byte
  // count or has one bit flipped. The checksum is computed over the IPv4
  // pseudo-header and the segment, then kept, replaced by a wrong nonzero
  // value or zeroed. A negative fill gives random payload bytes.
  task automatic send_datagram(input int unsigned seg_total, input logic [15:0] sp,
                               input logic [15:0] dp, input bit len_ok,
                               input csum_kind_t kind, input logic [31:0] sa,
                               input logic [31:0] da, input int fill = -1);
    logic [15:0] len_field;
    logic [15:0] good;
    logic [15:0] csum;
    logic [63:0] hdr;
    seg.delete();
    len_field = seg_total[15:0];
    if (!len_ok) len_field = len_field ^ (16'h0001 << $urandom_range(15, 0));
    hdr = {sp, dp, len_field, 16'h0000};
    for (int unsigned i = 0; i < seg_total; i++)
      seg.push_back(fill < 0 ? 8'($urandom_range(255, 0)) : 8'(fill));
    for (int unsigned i = 0; i < 8 && i < seg_total; i++) seg[i] = hdr[63 - 8*i -: 8];

    // Pseudo-header first, then the segment with its checksum field still zero.
    good = csum_add(16'h0, {16'h0, sa[31:16]});
    good = csum_add(good, {16'h0, sa[15:0]});
    good = csum_add(good, {16'h0, da[31:16]});
    good = csum_add(good, {16'h0, da[15:0]});
    good = csum_add(good, 32'd17);
    good = csum_add(good, {15'h0, seg_total[16:0]});
    for (int unsigned i = 0; i < seg_total; i += 2)
      good = csum_add(good, {16'h0, seg[i], (i + 1 < seg_total) ? seg[i+1] : 8'h00});
    good = ~good;
    if (good == 16'h0) good = 16'hffff;

    case (kind)
      CSUM_GOOD: csum = good;
      CSUM_ZERO: csum = 16'h0;
      default: begin
        csum = 16'($urandom);
        while (csum == good || csum == 16'h0) csum = 16'($urandom);
      end
    endcase
    if (seg_total > 6) seg[6] = csum[15:8];
    if (seg_total > 7) seg[7] = csum[7:0];

    // Valid stays high across back-to-back words; each cycle may idle at random.
    for (int i = 0; i < seg.size(); i++) begin
      @(negedge clk);
      while (!steady && $urandom_range(99, 0) < IDLE_PERCENT) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.data_byte <= seg[i];
      in_ch.last_byte <= (i == seg.size() - 1);
      in_ch.src_ip    <= sa;
      in_ch.dst_ip    <= da;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      bytes_sent++;
    end
    segments_sent++;
  endtask

  // Holds the sender back until every predicted verdict has come out, then
  // lets the pipeline empty of trailing bytes that carry no result.
  task automatic await_quiet();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Configuration is only changed with the block idle.
  task automatic reconfigure(input logic allow_zero);
    await_quiet();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= allow_zero;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    rst_n           = 1'b0;
    steady          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    in_ch.src_ip    = 32'h0;
    in_ch.dst_ip    = 32'h0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = 1'b0;
    bytes_sent      = 0;
    segments_sent   = 0;
    cfg_writes      = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Zero checksums are refused first.
    reconfigure(1'b0);
    // Segments shorter than the header: bad length, ports only as far as received.
    send_datagram(1, 16'hffff, 16'hffff, 1'b1, CSUM_GOOD, 32'h0, 32'h0, 8'hff);
    send_datagram(4, 16'h1234, 16'habcd, 1'b1, CSUM_GOOD, 32'hffffffff, 32'h0);
    send_datagram(7, 16'h0400, 16'h0035, 1'b1, CSUM_GOOD, 32'h0, 32'hffffffff);
    // Header only with all-ones fields and addresses, then an odd segment of zeros
    // whose last byte needs padding.
    send_datagram(8, 16'hffff, 16'hffff, 1'b1, CSUM_GOOD, 32'hffffffff, 32'hffffffff, 8'hff);
    send_datagram(9, 16'h0000, 16'h0035, 1'b1, CSUM_GOOD, 32'h0, 32'h0, 8'h00);
    // Length field disagreeing with the byte count.
    send_datagram(20, 16'd1000, 16'd53, 1'b0, CSUM_GOOD, 32'hc0a80001, 32'hc0a80002);
    // Zero destination port with a good checksum, then a wrong checksum.
    send_datagram(30, 16'd7, 16'h0000, 1'b1, CSUM_GOOD, 32'h0a000001, 32'h0a0000fe);
    send_datagram(25, 16'd5, 16'd6, 1'b1, CSUM_WRONG, 32'h7f000001, 32'h7f000001);
    // Zero checksum refused; it outranks a zero destination port.
    send_datagram(16, 16'd5, 16'd6, 1'b1, CSUM_ZERO, 32'h01020304, 32'h05060708);
    send_datagram(16, 16'd5, 16'h0000, 1'b1, CSUM_ZERO, 32'h01020304, 32'h05060708);

    // Zero checksums now pass without the sum being looked at.
    reconfigure(1'b1);
    send_datagram(16, 16'd5, 16'd6, 1'b1, CSUM_ZERO, 32'h01020304, 32'h05060708);
    send_datagram(17, 16'd5, 16'h0000, 1'b1, CSUM_ZERO, 32'h01020304, 32'h05060708);
    send_datagram(16, 16'd5, 16'd6, 1'b1, CSUM_WRONG, 32'h01020304, 32'h05060708);

    // Random part: mostly well-formed segments with random content, mixed with
    // short, mislabeled, badly summed and zero-port ones. Each phase of
    // PHASE_SEGS segments after the first starts from an idle block with a new
    // register value; the second phase runs without any idling on either side.
    random_start = bytes_sent;
    random_segs  = 0;
    while (bytes_sent - random_start < RANDOM_BYTES || random_segs < RANDOM_SEGS) begin
      if (random_segs != 0 && random_segs % PHASE_SEGS == 0)
        reconfigure(1'($urandom_range(1, 0)));
      steady  = (random_segs >= PHASE_SEGS && random_segs < 2 * PHASE_SEGS);
      pick    = $urandom_range(99, 0);
      seg_len = (pick < 5) ? $urandom_range(7, 1) : 8 + $urandom_range(24, 0);
      sport   = 16'($urandom);
      dport   = (pick >= 93) ? 16'h0000 : 16'($urandom);
      src     = $urandom;
      dst     = $urandom;
      if ($urandom_range(3, 0) == 0) begin
        src = $urandom_range(1, 0) ? 32'hffffffff : 32'h0;
        dst = $urandom_range(1, 0) ? 32'hffffffff : 32'h0;
      end
      send_datagram(seg_len, sport, dport, !(pick >= 85 && pick < 93),
                    (pick >= 65 && pick < 75) ? CSUM_WRONG :
                    (pick >= 75 && pick < 85) ? CSUM_ZERO : CSUM_GOOD, src, dst);
      random_segs++;
    end
    steady = 1'b0;

    await_quiet();
    $display("Sent %0d bytes in %0d segments with %0d register writes; %0d verdicts checked.",
             bytes_sent, segments_sent, cfg_writes, verdicts_checked);
    $display("Covered short, mislabeled, badly summed and zero-port segments %s",
             "under both zero-checksum settings, with and without stalls.");
    if (mismatches == 0) begin
      $display("udp_datagram_rx_checker verification clean");
    end else begin
      $display("udp_datagram_rx_checker verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/udrc_pkg.sv
hdl/udrc_if.sv
hdl/udrc_accum.sv
hdl/udrc_verdict.sv
hdl/udp_datagram_rx_checker.sv
bench/udrc_result_checker.sv
bench/tb_udp_datagram_rx_checker.sv
